// ===== rtl/coe_pkg.sv =====
// ----------------------------------------------------------------------------
// coe_pkg - clock offset estimator shared definitions
// Field widths, message codes, register map and divider constants.
// ----------------------------------------------------------------------------
`default_nettype none

package coe_pkg;

	// Field widths of the message and result beats
	localparam int TYPE_W   = 8;
	localparam int SEQ_W    = 16;
	localparam int IDENT_W  = 16;
	localparam int LTIME_W  = 27;   // local milliseconds of day
	localparam int RTIME_W  = 32;   // partner timestamps
	localparam int OFFSET_W = 34;
	localparam int REASON_W = 2;
	localparam int SEC_W    = 25;
	localparam int USEC_W   = 21;
	localparam int RETRY_W  = 8;

	// Message codes
	localparam logic [TYPE_W-1:0] TSTAMP_REPLY = 8'd14;
	localparam logic [SEQ_W-1:0]  EXPECTED_SEQ = 16'd512;

	// Reset values
	localparam logic [RETRY_W-1:0] RETRY_RESET     = 8'd15;
	localparam logic [IDENT_W-1:0] IDENT_RESET     = 16'd0;
	localparam logic signed [31:0] LEAST_RTT_RESET = 32'sd2147483647;

	// Register map: register i at byte address 4*i
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_RETRY_RELOAD   = 1'b0;
	localparam logic REG_EXPECTED_IDENT = 1'b1;

	// Millisecond split: x / 1000 = (x >> 3) / 125, the latter by a
	// reciprocal multiply that is exact for quotients of 30-bit values.
	localparam int MS_PER_SEC_SHIFT       = 3;
	localparam logic [30:0] DIV125_MUL    = 31'd1099511628;
	localparam int DIV125_SHIFT           = 37;
	localparam logic [9:0] MS_PER_SEC     = 10'd1000;
	localparam logic [9:0] USEC_PER_MS    = 10'd1000;

endpackage

`default_nettype wire

// ===== rtl/coe_msg_if.sv =====
// ----------------------------------------------------------------------------
// coe_msg_if - timestamp message channel
// Valid/ready channel carrying one received timestamp message per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface coe_msg_if;

	logic                           valid;
	logic                           ready;
	logic [coe_pkg::TYPE_W-1:0]     msg_type;
	logic [coe_pkg::SEQ_W-1:0]      seq_number;
	logic [coe_pkg::IDENT_W-1:0]    ident;
	logic [coe_pkg::LTIME_W-1:0]    originate_ms;
	logic [coe_pkg::RTIME_W-1:0]    remote_receive_ms;
	logic [coe_pkg::RTIME_W-1:0]    remote_transmit_ms;
	logic [coe_pkg::LTIME_W-1:0]    local_arrival_ms;

	modport source (
		output valid, msg_type, seq_number, ident, originate_ms,
		       remote_receive_ms, remote_transmit_ms, local_arrival_ms,
		input  ready
	);

	modport sink (
		input  valid, msg_type, seq_number, ident, originate_ms,
		       remote_receive_ms, remote_transmit_ms, local_arrival_ms,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/coe_res_if.sv =====
// ----------------------------------------------------------------------------
// coe_res_if - offset result channel
// Valid/ready channel carrying one offset estimate per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface coe_res_if;

	logic                                valid;
	logic                                ready;
	logic                                accepted;
	logic                                seq_mismatch;
	logic                                ident_mismatch;
	logic signed [coe_pkg::OFFSET_W-1:0] offset_ms;
	logic [coe_pkg::REASON_W-1:0]        adjust_reason;
	logic signed [coe_pkg::SEC_W-1:0]    adjust_sec;
	logic signed [coe_pkg::USEC_W-1:0]   adjust_usec;
	logic [coe_pkg::RETRY_W-1:0]         retries_left;

	modport source (
		output valid, accepted, seq_mismatch, ident_mismatch, offset_ms,
		       adjust_reason, adjust_sec, adjust_usec, retries_left,
		input  ready
	);

	modport sink (
		input  valid, accepted, seq_mismatch, ident_mismatch, offset_ms,
		       adjust_reason, adjust_sec, adjust_usec, retries_left,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/clock_offset_estimator.sv =====
// ----------------------------------------------------------------------------
// clock_offset_estimator - NTP-style clock offset with least round trip filter
// Eight-stage pipeline: offset arithmetic, millisecond split and adjust logic.
// ----------------------------------------------------------------------------
// Pipeline: a message beat accepted from msg passes through one register per stage
//   on its way to res, and the last stage register is the output register.
// Throughput: one message per cycle while res is ready; every stage advances on its own when the
//   stage after it is empty or moving, so stalls on res fill bubbles first.
// Reset: arst_n clears all stage valids, reloads the countdown with 15, the
//   least round trip with 2147483647 and the registers with their defaults.
`default_nettype none

module clock_offset_estimator (
	input  wire                              clk,
	input  wire                              arst_n,
	// APB-style configuration port
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [coe_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire [coe_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [coe_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	// channels
	coe_msg_if.sink                          msg,
	coe_res_if.source                        res
);

	localparam int NSTG = 8;

	typedef enum logic [coe_pkg::REASON_W-1:0] {
		RSN_NONE    = 2'd0,
		RSN_EXPIRED = 2'd1,
		RSN_NEW_MIN = 2'd2
	} reason_t;

	// control fields that ride along with the arithmetic
	typedef struct packed {
		logic                          accepted;
		logic                          seq_mis;
		logic                          ident_mis;
		reason_t                       reason;
		logic [coe_pkg::RETRY_W-1:0]   retries;
	} ctl_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [coe_pkg::RETRY_W-1:0] retry_reload_q;
	logic [coe_pkg::IDENT_W-1:0] exp_ident_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_reload_q <= coe_pkg::RETRY_RESET;
			exp_ident_q    <= coe_pkg::IDENT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				coe_pkg::REG_RETRY_RELOAD:   retry_reload_q <= pwdata[coe_pkg::RETRY_W-1:0];
				coe_pkg::REG_EXPECTED_IDENT: exp_ident_q    <= pwdata[coe_pkg::IDENT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			coe_pkg::REG_RETRY_RELOAD:
				prdata = {{(coe_pkg::APB_DATA_W-coe_pkg::RETRY_W){1'b0}}, retry_reload_q};
			coe_pkg::REG_EXPECTED_IDENT:
				prdata = {{(coe_pkg::APB_DATA_W-coe_pkg::IDENT_W){1'b0}}, exp_ident_q};
			default:
				prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Stage handshake: a stage takes a new beat when it is empty or when
	// the stage after it takes its current one.
	// ------------------------------------------------------------------
	logic [NSTG-1:0] stg_vld_q;
	logic [NSTG-1:0] stg_rdy;

	always_comb begin
		stg_rdy[NSTG-1] = !stg_vld_q[NSTG-1] || res.ready;
		for (int i = NSTG-2; i >= 0; i--) begin
			stg_rdy[i] = !stg_vld_q[i] || stg_rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (stg_rdy[0]) begin
				stg_vld_q[0] <= msg.valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (stg_rdy[i]) begin
					stg_vld_q[i] <= stg_vld_q[i-1];
				end
			end
		end
	end

	assign msg.ready = stg_rdy[0];
	assign res.valid = stg_vld_q[NSTG-1];

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic [coe_pkg::TYPE_W-1:0]  msg_type_s1;
	logic [coe_pkg::SEQ_W-1:0]   seq_s1;
	logic [coe_pkg::IDENT_W-1:0] ident_s1;
	logic [coe_pkg::LTIME_W-1:0] orig_s1;
	logic [coe_pkg::RTIME_W-1:0] rrecv_s1;
	logic [coe_pkg::RTIME_W-1:0] rtrans_s1;
	logic [coe_pkg::LTIME_W-1:0] arr_s1;

	always_ff @(posedge clk) begin
		if (stg_rdy[0]) begin
			msg_type_s1 <= msg.msg_type;
			seq_s1      <= msg.seq_number;
			ident_s1    <= msg.ident;
			orig_s1     <= msg.originate_ms;
			rrecv_s1    <= msg.remote_receive_ms;
			rtrans_s1   <= msg.remote_transmit_ms;
			arr_s1      <= msg.local_arrival_ms;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 -> 2: round trip, residence, filter state update
	// ------------------------------------------------------------------
	logic signed [coe_pkg::LTIME_W:0]    rtt_c;     // 28 bits
	logic signed [coe_pkg::RTIME_W:0]    resid_c;   // 33 bits
	logic signed [coe_pkg::OFFSET_W-1:0] tam_c;     // transmit minus arrival
	logic                                is_reply;
	logic                                upd;
	logic [coe_pkg::RETRY_W-1:0]         cd_dec;
	ctl_t                                ctl_c;
	logic [coe_pkg::RETRY_W-1:0]         countdown_d;
	logic signed [31:0]                  least_rtt_d;

	logic [coe_pkg::RETRY_W-1:0]         countdown_q;
	logic signed [31:0]                  least_rtt_q;

	assign rtt_c   = $signed({1'b0, arr_s1}) - $signed({1'b0, orig_s1});
	assign resid_c = $signed({1'b0, rtrans_s1}) - $signed({1'b0, rrecv_s1});
	assign tam_c   = $signed({2'b00, rtrans_s1})
	               - $signed({{(coe_pkg::OFFSET_W-coe_pkg::LTIME_W){1'b0}}, arr_s1});

	assign is_reply = (msg_type_s1 == coe_pkg::TSTAMP_REPLY);
	assign upd      = stg_vld_q[0] && stg_rdy[1] && is_reply;
	assign cd_dec   = countdown_q - 1'b1;

	always_comb begin
		countdown_d   = countdown_q;
		least_rtt_d   = least_rtt_q;
		ctl_c         = '0;
		ctl_c.reason  = RSN_NONE;
		ctl_c.retries = countdown_q;
		if (is_reply) begin
			ctl_c.accepted  = 1'b1;
			ctl_c.seq_mis   = (seq_s1 != coe_pkg::EXPECTED_SEQ);
			ctl_c.ident_mis = (ident_s1 != exp_ident_q);
			countdown_d     = cd_dec;
			if (cd_dec == '0) begin
				// countdown ran out: force an adjustment and restart the filter
				ctl_c.reason = RSN_EXPIRED;
				countdown_d  = retry_reload_q;
				least_rtt_d  = coe_pkg::LEAST_RTT_RESET;
			end else if (32'(rtt_c) < least_rtt_q) begin
				ctl_c.reason = RSN_NEW_MIN;
				countdown_d  = retry_reload_q;
				least_rtt_d  = 32'(rtt_c);
			end
			ctl_c.retries = countdown_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= coe_pkg::RETRY_RESET;
			least_rtt_q <= coe_pkg::LEAST_RTT_RESET;
		end else if (upd) begin
			countdown_q <= countdown_d;
			least_rtt_q <= least_rtt_d;
		end
	end

	ctl_t                                ctl_s2;
	logic signed [coe_pkg::LTIME_W:0]    rtt_s2;
	logic signed [coe_pkg::RTIME_W:0]    resid_s2;
	logic signed [coe_pkg::OFFSET_W-1:0] tam_s2;

	always_ff @(posedge clk) begin
		if (stg_rdy[1]) begin
			ctl_s2   <= ctl_c;
			rtt_s2   <= rtt_c;
			resid_s2 <= resid_c;
			tam_s2   <= tam_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 -> 3: round trip minus residence, bumped by one when negative
	// so that the halving below truncates toward zero
	// ------------------------------------------------------------------
	logic signed [coe_pkg::OFFSET_W-1:0] diff_c;
	logic                                diff_neg;

	assign diff_neg = ($signed(33'(rtt_s2)) < resid_s2);
	assign diff_c   = $signed(34'(rtt_s2)) - $signed(34'(resid_s2))
	                + $signed({{(coe_pkg::OFFSET_W-1){1'b0}}, diff_neg});

	ctl_t                                ctl_s3;
	logic signed [coe_pkg::OFFSET_W-1:0] diff_s3;
	logic signed [coe_pkg::OFFSET_W-1:0] tam_s3;

	always_ff @(posedge clk) begin
		if (stg_rdy[2]) begin
			ctl_s3  <= ctl_s2;
			diff_s3 <= diff_c;
			tam_s3  <= tam_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3 -> 4: offset = back delay + transmit - arrival
	// ------------------------------------------------------------------
	ctl_t                                ctl_s4;
	logic signed [coe_pkg::OFFSET_W-1:0] offset_s4;

	always_ff @(posedge clk) begin
		if (stg_rdy[3]) begin
			ctl_s4    <= ctl_s3;
			offset_s4 <= (diff_s3 >>> 1) + tam_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4 -> 5: sign and magnitude (magnitude stays below 2^33)
	// ------------------------------------------------------------------
	logic [coe_pkg::OFFSET_W-1:0] mag_c;

	assign mag_c = offset_s4[coe_pkg::OFFSET_W-1] ? (~offset_s4 + 1'b1) : offset_s4;

	ctl_t                                ctl_s5;
	logic signed [coe_pkg::OFFSET_W-1:0] offset_s5;
	logic                                neg_s5;
	logic [coe_pkg::OFFSET_W-2:0]        mag_s5;

	always_ff @(posedge clk) begin
		if (stg_rdy[4]) begin
			ctl_s5    <= ctl_s4;
			offset_s5 <= offset_s4;
			neg_s5    <= offset_s4[coe_pkg::OFFSET_W-1];
			mag_s5    <= mag_c[coe_pkg::OFFSET_W-2:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 5 -> 6: seconds = (mag >> 3) / 125 by reciprocal multiply
	// ------------------------------------------------------------------
	localparam int Y_W    = coe_pkg::OFFSET_W - 1 - coe_pkg::MS_PER_SEC_SHIFT;  // 30
	localparam int PROD_W = Y_W + 31;
	localparam int Q_W    = PROD_W - coe_pkg::DIV125_SHIFT;                    // 24

	logic [Y_W-1:0]    div_y;
	logic [PROD_W-1:0] div_prod;

	assign div_y    = mag_s5[coe_pkg::OFFSET_W-2:coe_pkg::MS_PER_SEC_SHIFT];
	assign div_prod = PROD_W'(div_y) * PROD_W'(coe_pkg::DIV125_MUL);

	ctl_t                                ctl_s6;
	logic signed [coe_pkg::OFFSET_W-1:0] offset_s6;
	logic                                neg_s6;
	logic [coe_pkg::OFFSET_W-2:0]        mag_s6;
	logic [Q_W-1:0]                      quo_s6;

	always_ff @(posedge clk) begin
		if (stg_rdy[5]) begin
			ctl_s6    <= ctl_s5;
			offset_s6 <= offset_s5;
			neg_s6    <= neg_s5;
			mag_s6    <= mag_s5;
			quo_s6    <= div_prod[PROD_W-1:coe_pkg::DIV125_SHIFT];
		end
	end

	// ------------------------------------------------------------------
	// Stage 6 -> 7: remainder = mag - seconds * 1000
	// ------------------------------------------------------------------
	logic [coe_pkg::OFFSET_W-2:0] q_scaled;
	logic [coe_pkg::OFFSET_W-2:0] rem_full;

	assign q_scaled = (coe_pkg::OFFSET_W-1)'(quo_s6) * (coe_pkg::OFFSET_W-1)'(coe_pkg::MS_PER_SEC);
	assign rem_full = mag_s6 - q_scaled;

	ctl_t                                ctl_s7;
	logic signed [coe_pkg::OFFSET_W-1:0] offset_s7;
	logic                                neg_s7;
	logic [Q_W-1:0]                      quo_s7;
	logic [9:0]                          rem_s7;

	always_ff @(posedge clk) begin
		if (stg_rdy[6]) begin
			ctl_s7    <= ctl_s6;
			offset_s7 <= offset_s6;
			neg_s7    <= neg_s6;
			quo_s7    <= quo_s6;
			rem_s7    <= rem_full[9:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 7 -> 8: apply the sign, scale the remainder, zero non-replies
	// ------------------------------------------------------------------
	logic [coe_pkg::USEC_W-2:0]        usec_mag;
	logic signed [coe_pkg::SEC_W-1:0]  sec_c;
	logic signed [coe_pkg::USEC_W-1:0] usec_c;

	assign usec_mag = (coe_pkg::USEC_W-1)'(rem_s7) * (coe_pkg::USEC_W-1)'(coe_pkg::USEC_PER_MS);
	assign sec_c    = neg_s7 ? -$signed({1'b0, quo_s7}) : $signed({1'b0, quo_s7});
	assign usec_c   = neg_s7 ? -$signed({1'b0, usec_mag}) : $signed({1'b0, usec_mag});

	ctl_t                                ctl_s8;
	logic signed [coe_pkg::OFFSET_W-1:0] offset_s8;
	logic signed [coe_pkg::SEC_W-1:0]    sec_s8;
	logic signed [coe_pkg::USEC_W-1:0]   usec_s8;

	always_ff @(posedge clk) begin
		if (stg_rdy[7]) begin
			ctl_s8    <= ctl_s7;
			offset_s8 <= ctl_s7.accepted ? offset_s7 : '0;
			sec_s8    <= ctl_s7.accepted ? sec_c : '0;
			usec_s8   <= ctl_s7.accepted ? usec_c : '0;
		end
	end

	assign res.accepted       = ctl_s8.accepted;
	assign res.seq_mismatch   = ctl_s8.seq_mis;
	assign res.ident_mismatch = ctl_s8.ident_mis;
	assign res.offset_ms      = offset_s8;
	assign res.adjust_reason  = ctl_s8.reason;
	assign res.adjust_sec     = sec_s8;
	assign res.adjust_usec    = usec_s8;
	assign res.retries_left   = ctl_s8.retries;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// any adjustment reloads the countdown
	a_reload_on_adjust: assert property (@(posedge clk) disable iff (!arst_n)
		stg_vld_q[1] && ctl_s2.reason != RSN_NONE |-> ctl_s2.retries == retry_reload_q)
		else $error("adjustment without countdown reload");

	// reciprocal divide must leave a remainder below one second
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		stg_vld_q[6] |-> rem_s7 < coe_pkg::MS_PER_SEC)
		else $error("millisecond remainder out of range");

	// non-replies carry no offset or adjustment
	a_nonreply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.accepted |->
			res.offset_ms == '0 && res.adjust_sec == '0 && res.adjust_usec == '0 &&
			res.adjust_reason == RSN_NONE && !res.seq_mismatch && !res.ident_mismatch)
		else $error("non-reply result carries data");

	// a non-negative offset splits into non-negative parts
	a_split_sign: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.offset_ms[coe_pkg::OFFSET_W-1] |->
			!res.adjust_sec[coe_pkg::SEC_W-1] && !res.adjust_usec[coe_pkg::USEC_W-1])
		else $error("offset split has wrong sign");

	// filter state moves only on a reply entering stage 2
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(upd) && $past(arst_n) |-> $stable(countdown_q) && $stable(least_rtt_q))
		else $error("filter state changed without a reply");

endmodule

`default_nettype wire

// ===== bench/coe_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coe_tb_pkg - clock offset estimator bench types and result scoreboard
// Beat types for both channels and a scoreboard that predicts each offset
// estimate from the accepted message and checks the result beats in order.
// ----------------------------------------------------------------------------

package coe_tb_pkg;

	import coe_pkg::*;

	localparam longint MSEC_PER_SECOND = 1000;
	localparam longint USEC_IN_MS      = 1000;

	typedef enum logic [REASON_W-1:0] {
		ADJ_NONE    = 2'd0,
		ADJ_EXPIRED = 2'd1,
		ADJ_NEW_MIN = 2'd2
	} adjust_reason_e;

	typedef struct packed {
		logic [TYPE_W-1:0]  msg_type;
		logic [SEQ_W-1:0]   seq_number;
		logic [IDENT_W-1:0] ident;
		logic [LTIME_W-1:0] originate_ms;
		logic [RTIME_W-1:0] remote_receive_ms;
		logic [RTIME_W-1:0] remote_transmit_ms;
		logic [LTIME_W-1:0] local_arrival_ms;
	} coe_msg_t;

	typedef struct packed {
		logic                accepted;
		logic                seq_mismatch;
		logic                ident_mismatch;
		logic [OFFSET_W-1:0] offset_ms;
		logic [REASON_W-1:0] adjust_reason;
		logic [SEC_W-1:0]    adjust_sec;
		logic [USEC_W-1:0]   adjust_usec;
		logic [RETRY_W-1:0]  retries_left;
	} coe_result_t;

	class offset_scoreboard;

		logic [RETRY_W-1:0] retry_reload;
		logic [IDENT_W-1:0] ident_want;
		logic [RETRY_W-1:0] countdown;
		longint             least_rtt;
		coe_result_t        pending_estimates[$];
		int                 errors;

		function new();
			retry_reload = RETRY_RESET;
			ident_want   = IDENT_RESET;
			countdown    = RETRY_RESET;
			least_rtt    = LEAST_RTT_RESET;
			errors       = 0;
		endfunction

		function void set_reload(logic [RETRY_W-1:0] value);
			retry_reload = value;
		endfunction

		function void set_ident(logic [IDENT_W-1:0] value);
			ident_want = value;
		endfunction

		function int pending();
			return pending_estimates.size();
		endfunction

		// Predict the estimate for one accepted message and queue it.
		function void note_message(coe_msg_t m);
			coe_result_t e;
			longint      originate, arrival, rrecv, rtrans;
			longint      rtt, residence, back_delay, offset, secs, usecs;
			e = '0;
			if (m.msg_type == TSTAMP_REPLY) begin
				originate  = m.originate_ms;
				arrival    = m.local_arrival_ms;
				rrecv      = m.remote_receive_ms;
				rtrans     = m.remote_transmit_ms;
				rtt        = arrival - originate;
				residence  = rtrans - rrecv;
				back_delay = (rtt - residence) / 2;
				offset     = rtrans + back_delay - arrival;
				secs       = offset / MSEC_PER_SECOND;
				usecs      = (offset % MSEC_PER_SECOND) * USEC_IN_MS;

				countdown = countdown - 1'b1;
				if (countdown == '0) begin
					e.adjust_reason = ADJ_EXPIRED;
					countdown       = retry_reload;
					least_rtt       = LEAST_RTT_RESET;
				end else if (rtt < least_rtt) begin
					e.adjust_reason = ADJ_NEW_MIN;
					least_rtt       = rtt;
					countdown       = retry_reload;
				end

				e.accepted       = 1'b1;
				e.seq_mismatch   = (m.seq_number != EXPECTED_SEQ);
				e.ident_mismatch = (m.ident != ident_want);
				e.offset_ms      = offset[OFFSET_W-1:0];
				e.adjust_sec     = secs[SEC_W-1:0];
				e.adjust_usec    = usecs[USEC_W-1:0];
			end
			e.retries_left = countdown;
			pending_estimates.push_back(e);
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, actual %0h",
					$time, field, want, got);
			end
		endfunction

		// Check one result beat against the oldest queued estimate.
		function void check_result(coe_result_t got);
			coe_result_t want;
			if (pending_estimates.size() == 0) begin
				errors++;
				$display("%0t: result beat with no estimate pending: expected none, actual %0h",
					$time, got);
				return;
			end
			want = pending_estimates.pop_front();
			compare_field("accepted",       want.accepted,       got.accepted);
			compare_field("seq_mismatch",   want.seq_mismatch,   got.seq_mismatch);
			compare_field("ident_mismatch", want.ident_mismatch, got.ident_mismatch);
			compare_field("offset_ms",      want.offset_ms,      got.offset_ms);
			compare_field("adjust_reason",  want.adjust_reason,  got.adjust_reason);
			compare_field("adjust_sec",     want.adjust_sec,     got.adjust_sec);
			compare_field("adjust_usec",    want.adjust_usec,    got.adjust_usec);
			compare_field("retries_left",   want.retries_left,   got.retries_left);
		endfunction

	endclass

endpackage

// ===== bench/clock_offset_estimator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_offset_estimator_tb - bench for the clock offset estimator
// Drives timestamp message beats and APB register writes, predicts every
// offset estimate in a scoreboard and checks each result beat field by field.
// A directed opening covers field extremes, non-replies, truncation of
// negative values, countdown expiry, new least round trips and a zero reload;
// random phases then sweep register settings and handshake idling.
// ----------------------------------------------------------------------------

module clock_offset_estimator_tb;

	import coe_pkg::*;
	import coe_tb_pkg::*;

	localparam int LATENCY         = 8;
	localparam int HOLD_CYCLES     = 80;
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int SETTLE_LIMIT    = 20000;
	localparam int TIMEOUT_NS      = 2000000;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	coe_msg_if msg();
	coe_res_if res();

	// Idle rates in percent per cycle, and the request for a long receiver hold
	int unsigned send_idle;
	int unsigned recv_idle;
	bit          hold_off_req;

	offset_scoreboard sb;
	coe_result_t      seen_result;

	clock_offset_estimator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.msg     (msg),
		.res     (res)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the handshakes hang
	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver: pick ready at each falling edge; on request hold it low for a
	// long stretch so the pipeline fills and backs up into the message channel.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res.ready    = 1'b0;
				hold_off_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			res.ready = ($urandom_range(99) >= recv_idle);
		end
	end

	// Monitor: take every result beat at the rising edge and check it.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			seen_result.accepted       = res.accepted;
			seen_result.seq_mismatch   = res.seq_mismatch;
			seen_result.ident_mismatch = res.ident_mismatch;
			seen_result.offset_ms      = res.offset_ms;
			seen_result.adjust_reason  = res.adjust_reason;
			seen_result.adjust_sec     = res.adjust_sec;
			seen_result.adjust_usec    = res.adjust_usec;
			seen_result.retries_left   = res.retries_left;
			sb.check_result(seen_result);
		end
	end

	// Write one register through the APB port: setup, then access.
	// Enter and leave at a falling edge.
	task automatic write_register(input logic reg_index, input logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {reg_index, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		// the register takes the new value at this edge
		if (reg_index == REG_RETRY_RELOAD)
			sb.set_reload(value[RETRY_W-1:0]);
		else
			sb.set_ident(value[IDENT_W-1:0]);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Offer one message beat, with random idle cycles ahead of it, and hold it
	// until the block takes it. Enter and leave at a falling edge.
	task automatic send_message(input coe_msg_t m);
		while ($urandom_range(99) < send_idle) begin
			msg.valid = 1'b0;
			@(negedge clk);
		end
		msg.valid              = 1'b1;
		msg.msg_type           = m.msg_type;
		msg.seq_number         = m.seq_number;
		msg.ident              = m.ident;
		msg.originate_ms       = m.originate_ms;
		msg.remote_receive_ms  = m.remote_receive_ms;
		msg.remote_transmit_ms = m.remote_transmit_ms;
		msg.local_arrival_ms   = m.local_arrival_ms;
		do @(posedge clk); while (!msg.ready);
		sb.note_message(m);
		@(negedge clk);
	endtask

	// Drop valid and wait for the block to drain, then a few more cycles.
	task automatic settle();
		int guard = 0;
		msg.valid = 1'b0;
		while (sb.pending() != 0 && guard < SETTLE_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic coe_msg_t make_message(
		input logic [TYPE_W-1:0]  mtype,
		input logic [SEQ_W-1:0]   seq,
		input logic [IDENT_W-1:0] id,
		input logic [LTIME_W-1:0] originate,
		input logic [RTIME_W-1:0] rrecv,
		input logic [RTIME_W-1:0] rtrans,
		input logic [LTIME_W-1:0] arrival
	);
		return '{mtype, seq, id, originate, rrecv, rtrans, arrival};
	endfunction

	// Mostly well-formed replies with plausible timestamps; the rest is noise.
	function automatic coe_msg_t random_message();
		coe_msg_t    m;
		int unsigned rtt;
		int          skew;
		m.msg_type   = ($urandom_range(99) < 85) ? TSTAMP_REPLY : TYPE_W'($urandom);
		m.seq_number = ($urandom_range(3) == 0) ? SEQ_W'($urandom) : EXPECTED_SEQ;
		m.ident      = ($urandom_range(3) == 0) ? IDENT_W'($urandom) : sb.ident_want;
		if ($urandom_range(9) < 7) begin
			// realistic exchange: short round trip, partner clock a little off
			rtt                  = $urandom_range(0, 3000);
			skew                 = int'($urandom_range(0, 20000)) - 10000;
			m.originate_ms       = LTIME_W'($urandom_range(0, 86390000));
			m.local_arrival_ms   = m.originate_ms + LTIME_W'(rtt);
			m.remote_receive_ms  = RTIME_W'(m.originate_ms) + RTIME_W'(skew)
				+ RTIME_W'(rtt / 2);
			m.remote_transmit_ms = m.remote_receive_ms + RTIME_W'($urandom_range(0, 40));
		end else begin
			// any bit pattern, wrapped days and reversed clocks included
			m.originate_ms       = LTIME_W'($urandom);
			m.remote_receive_ms  = $urandom;
			m.remote_transmit_ms = $urandom;
			m.local_arrival_ms   = LTIME_W'($urandom);
		end
		return m;
	endfunction

	initial begin
		int                 phase;
		int                 n;
		logic [RETRY_W-1:0] reload;
		logic [IDENT_W-1:0] ident_val;

		sb = new();

		// Drive every input to a known value before reset lifts
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		msg.valid    = 1'b0;
		msg.msg_type           = '0;
		msg.seq_number         = '0;
		msg.ident              = '0;
		msg.originate_ms       = '0;
		msg.remote_receive_ms  = '0;
		msg.remote_transmit_ms = '0;
		msg.local_arrival_ms   = '0;
		hold_off_req = 1'b0;
		send_idle    = 35;
		recv_idle    = 54;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- Directed opening -------------------------------------------------
		// Reset register values: non-replies at both extremes, then a plain
		// reply that sets the first least round trip.
		send_message(make_message(8'h00, '0, '0, '0, '0, '0, '0));
		send_message(make_message(8'hFF, '1, '1, '1, '1, '1, '1));
		send_message(make_message(TSTAMP_REPLY, EXPECTED_SEQ, IDENT_RESET,
			27'd1000, 32'd5000, 32'd5010, 27'd1100));
		// types next to the reply code are ignored too
		send_message(make_message(TSTAMP_REPLY - 8'd1, EXPECTED_SEQ, '0,
			27'd1, 32'd2, 32'd3, 27'd4));
		send_message(make_message(TSTAMP_REPLY + 8'd1, EXPECTED_SEQ, '0,
			27'd1, 32'd2, 32'd3, 27'd4));

		// Short reload so the countdown runs out inside the directed part
		settle();
		write_register(REG_RETRY_RELOAD, 32'd2);
		write_register(REG_EXPECTED_IDENT, 32'h0000FFFF);

		// all-zero reply: zero round trip is a new least, identifier mismatch
		send_message(make_message(TSTAMP_REPLY, EXPECTED_SEQ, '0, '0, '0, '0, '0));
		// large positive offset, long round trip: countdown only
		send_message(make_message(TSTAMP_REPLY, EXPECTED_SEQ, 16'hFFFF,
			'0, '0, '1, '1));
		// large positive offset and negative round trip: expiry wins over a new least
		send_message(make_message(TSTAMP_REPLY, EXPECTED_SEQ, 16'hFFFF,
			'1, '1, '0, '0));
		// odd positive difference: half back delay truncates down
		send_message(make_message(TSTAMP_REPLY, 16'hFFFF, 16'hFFFF,
			27'd0, 32'd10, 32'd10, 27'd3));
		// odd negative difference: truncates toward zero, new least round trip
		send_message(make_message(TSTAMP_REPLY, 16'd0, 16'd0,
			27'd3, 32'd10, 32'd10, 27'd0));
		// small negative offset with a sub-second remainder, no adjustment
		send_message(make_message(TSTAMP_REPLY, EXPECTED_SEQ, 16'hFFFF,
			27'd5000, 32'd3000, 32'd3766, 27'd5000));
		// offset of exactly minus one second
		send_message(make_message(TSTAMP_REPLY, EXPECTED_SEQ, 16'hFFFF,
			27'd2000, 32'd1000, 32'd1000, 27'd2000));

		// Zero reload: each adjustment loads 0 and a later reply with no adjustment wraps to 255
		settle();
		write_register(REG_RETRY_RELOAD, 32'd0);
		send_message(make_message(TSTAMP_REPLY, EXPECTED_SEQ, 16'hFFFF,
			27'd1000, 32'd7000, 32'd7000, 27'd2000));
		send_message(make_message(TSTAMP_REPLY, EXPECTED_SEQ, 16'hFFFF,
			27'd1000, 32'd7000, 32'd7000, 27'd1500));
		send_message(make_message(TSTAMP_REPLY, EXPECTED_SEQ, 16'hFFFF,
			27'd1000, 32'd7000, 32'd7000, 27'd1800));
		send_message(make_message(8'h00, EXPECTED_SEQ, 16'hFFFF,
			27'd1000, 32'd7000, 32'd7000, 27'd1800));
		send_message(make_message(TSTAMP_REPLY, EXPECTED_SEQ, 16'hFFFF,
			27'd1000, 32'd7000, 32'd7000, 27'd1900));

		// --- Random phases ----------------------------------------------------
		// Each phase: drain, reprogram both registers, then stream messages.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin
					reload    = 8'd1;
					ident_val = '0;
				end
				1: begin
					reload    = 8'd255;
					ident_val = '1;
				end
				3: begin
					reload    = '0;
					ident_val = IDENT_W'($urandom);
				end
				4: begin
					reload    = RETRY_RESET;
					ident_val = IDENT_W'($urandom);
				end
				default: begin
					reload    = RETRY_W'($urandom_range(1, 255));
					ident_val = IDENT_W'($urandom);
				end
			endcase

			// receiver-heavy idling, then sender-heavy, then none at all
			if (phase < 2) begin
				send_idle = 35;
				recv_idle = 54;
			end else if (phase < 4) begin
				send_idle = 54;
				recv_idle = 35;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end

			settle();
			write_register(REG_RETRY_RELOAD, {{(APB_DATA_W-RETRY_W){1'b0}}, reload});
			write_register(REG_EXPECTED_IDENT, {{(APB_DATA_W-IDENT_W){1'b0}}, ident_val});

			// stall the receiver long enough to back the pipeline up
			if (phase == 4)
				hold_off_req = 1'b1;

			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_message(random_message());
		end

		// Drain and allow a few extra cycles for any stray beat
		settle();
		repeat (2 * LATENCY) @(negedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== clock_offset_estimator.f =====
rtl/coe_pkg.sv
rtl/coe_msg_if.sv
rtl/coe_res_if.sv
rtl/clock_offset_estimator.sv
bench/coe_tb_pkg.sv
bench/clock_offset_estimator_tb.sv
